### hdl/pse_pkg.sv
// Shared types and constants of the prime sieve engine.
package pse_pkg;

    localparam int NUMBER_W = 16;
    localparam int LIMIT_W  = 17;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

    // Request type codes.
    localparam logic REQ_BUILD = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // First even number that the sieve clears, and first odd prime it sweeps.
    localparam int FIRST_EVEN_CLEARED = 4;
    localparam int FIRST_ODD_PRIME    = 3;

    typedef struct packed {
        logic                req_type;
        logic [NUMBER_W-1:0] number;
    } pse_req_t;

    typedef struct packed {
        logic prime_flag;
        logic answer_valid;
        logic build_done;
    } pse_resp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_CHECK,
        ST_TEST,
        ST_CROSS,
        ST_BUILD_END,
        ST_QUERY_RD
    } pse_state_t;

    typedef struct packed {
        logic accept;
        logic fill_clr;
        logic fill_write;
        logic fill_step;
        logic sieve_init;
        logic rd_i;
        logic rd_q;
        logic cross_start;
        logic cross_step;
        logic advance;
        logic build_commit;
        logic out_load_build;
        logic out_load_query;
    } pse_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic sq_lt_lim;
        logic j_lt_lim;
        logic rd_bit;
        logic out_free;
    } pse_status_t;

endpackage

### hdl/pse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pse_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/pse_datapath.sv
// Datapath of the prime sieve engine: limit register, sieve counters, table and result register.
module pse_datapath
    import pse_pkg::*;
#(
    parameter int SIEVE_SIZE = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pse_req_t            s_req,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    input  pse_cmd_t            cmd,
    output pse_status_t         status,
    input  logic                m_ready,
    output logic                m_valid,
    output pse_resp_t           m_resp
);

    localparam int AW  = $clog2(SIEVE_SIZE);
    localparam int CW  = $clog2(SIEVE_SIZE + 1);
    localparam int LW  = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int IW  = LW / 2 + 2;
    localparam int SW  = LW + 1;

    localparam logic [LW-1:0] SIZE_L    = LW'(SIEVE_SIZE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SIEVE_SIZE - 1);

    logic [LIMIT_W-1:0]  sieve_limit_reg, sieve_limit_next;
    logic [LW-1:0]       lim_reg, lim_next;
    logic [LW-1:0]       built_limit_reg, built_limit_next;
    logic                table_ready_reg, table_ready_next;
    logic [NUMBER_W-1:0] number_reg, number_next;
    logic [AW-1:0]       fill_cnt_reg, fill_cnt_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [SW-1:0]       sq_reg, sq_next;
    logic [SW-1:0]       j_reg, j_next;
    logic                m_valid_reg, m_valid_next;
    pse_resp_t           m_resp_reg, m_resp_next;

    logic [LW-1:0] lim_sat;
    logic [LW-1:0] fill_ext;
    logic          fill_clear;
    logic          query_ok;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic          ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic          ram_rd_data;

    assign lim_sat = (LW'(sieve_limit_reg) > SIZE_L) ? SIZE_L : LW'(sieve_limit_reg);

    // Zero, one, and the even numbers from four below the limit start out composite.
    assign fill_ext   = LW'(fill_cnt_reg);
    assign fill_clear = (fill_ext < LW'(2))
                     || ((fill_ext >= LW'(FIRST_EVEN_CLEARED)) && !fill_cnt_reg[0]
                         && (fill_ext < lim_reg));

    assign query_ok = table_ready_reg && (LW'(number_reg) < built_limit_reg);

    always_comb begin
        sieve_limit_next = sieve_limit_reg;
        lim_next         = lim_reg;
        built_limit_next = built_limit_reg;
        table_ready_next = table_ready_reg;
        number_next      = number_reg;
        fill_cnt_next    = fill_cnt_reg;
        i_next           = i_reg;
        sq_next          = sq_reg;
        j_next           = j_reg;
        m_valid_next     = m_valid_reg;
        m_resp_next      = m_resp_reg;

        if (cfg_wr_en) begin
            sieve_limit_next = cfg_wr_data;
        end
        if (cmd.accept) begin
            number_next = s_req.number;
            lim_next    = lim_sat;
        end
        if (cmd.fill_clr) begin
            fill_cnt_next = '0;
        end else if (cmd.fill_step) begin
            fill_cnt_next = fill_cnt_reg + AW'(1);
        end
        if (cmd.sieve_init) begin
            i_next  = IW'(FIRST_ODD_PRIME);
            sq_next = SW'(FIRST_ODD_PRIME * FIRST_ODD_PRIME);
        end else if (cmd.advance) begin
            // (i + 2)^2 = i^2 + 4i + 4
            i_next  = i_reg + IW'(2);
            sq_next = sq_reg + SW'({i_reg, 2'b00}) + SW'(4);
        end
        if (cmd.cross_start) begin
            j_next = sq_reg;
        end else if (cmd.cross_step) begin
            j_next = j_reg + SW'({i_reg, 1'b0});
        end
        if (cmd.build_commit) begin
            built_limit_next = lim_reg;
            table_ready_next = 1'b1;
        end
        if (cmd.out_load_build) begin
            m_valid_next = 1'b1;
            m_resp_next  = '{prime_flag: 1'b0, answer_valid: 1'b0, build_done: 1'b1};
        end else if (cmd.out_load_query) begin
            m_valid_next = 1'b1;
            m_resp_next  = '{prime_flag: query_ok & ram_rd_data, answer_valid: query_ok,
                             build_done: 1'b0};
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sieve_limit_reg <= LIMIT_RESET;
            built_limit_reg <= '0;
            table_ready_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            sieve_limit_reg <= sieve_limit_next;
            built_limit_reg <= built_limit_next;
            table_ready_reg <= table_ready_next;
            m_valid_reg     <= m_valid_next;
        end
        lim_reg      <= lim_next;
        number_reg   <= number_next;
        fill_cnt_reg <= fill_cnt_next;
        i_reg        <= i_next;
        sq_reg       <= sq_next;
        j_reg        <= j_next;
        m_resp_reg   <= m_resp_next;
    end

    assign ram_wr_en   = cmd.fill_write | cmd.cross_step;
    assign ram_wr_addr = cmd.fill_write ? fill_cnt_reg : AW'(j_reg);
    assign ram_wr_data = cmd.fill_write ? !fill_clear : 1'b0;
    assign ram_rd_en   = cmd.rd_q | cmd.rd_i;
    assign ram_rd_addr = cmd.rd_q ? AW'(s_req.number) : AW'(i_reg);

    pse_ram #(
        .WIDTH(1),
        .DEPTH(SIEVE_SIZE)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign status.fill_last = (fill_cnt_reg == LAST_ADDR);
    assign status.sq_lt_lim = (sq_reg < SW'(lim_reg));
    assign status.j_lt_lim  = (j_reg < SW'(lim_reg));
    assign status.rd_bit    = ram_rd_data;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_resp  = m_resp_reg;

    // Multiples that get crossed off are odd and start at nine.
    a_cross_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cross_step |-> (j_reg[0] && (j_reg >= SW'(9))))
        else $error("sieve clears an even or too small number");

    a_cross_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cross_step |-> (j_reg < SW'(lim_reg)))
        else $error("sieve clears a number at or above the limit");

endmodule

### hdl/pse_ctrl.sv
// Controller state machine of the prime sieve engine.
module pse_ctrl
    import pse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        req_type,
    output logic        s_ready,
    input  pse_status_t status,
    output pse_cmd_t    cmd
);

    pse_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (req_type == REQ_QUERY) ? ST_QUERY_RD : ST_FILL;
                end
            end
            ST_FILL: begin
                if (status.fill_last) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.sq_lt_lim ? ST_TEST : ST_BUILD_END;
            end
            ST_TEST: begin
                state_next = status.rd_bit ? ST_CROSS : ST_CHECK;
            end
            ST_CROSS: begin
                if (!status.j_lt_lim) begin
                    state_next = ST_CHECK;
                end
            end
            ST_BUILD_END, ST_QUERY_RD: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                // A query reads the table straight from the port number.
                cmd.rd_q     = s_valid && (req_type == REQ_QUERY);
                cmd.fill_clr = s_valid && (req_type == REQ_BUILD);
            end
            ST_FILL: begin
                cmd.fill_write = 1'b1;
                cmd.fill_step  = !status.fill_last;
                cmd.sieve_init = status.fill_last;
            end
            ST_CHECK: begin
                cmd.rd_i = status.sq_lt_lim;
            end
            ST_TEST: begin
                cmd.cross_start = status.rd_bit;
                cmd.advance     = !status.rd_bit;
            end
            ST_CROSS: begin
                cmd.cross_step = status.j_lt_lim;
                cmd.advance    = !status.j_lt_lim;
            end
            ST_BUILD_END: begin
                cmd.out_load_build = status.out_free;
                cmd.build_commit   = status.out_free;
            end
            ST_QUERY_RD: begin
                cmd.out_load_query = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load_build || cmd.out_load_query) |-> status.out_free)
        else $error("result register overwritten while still held");

endmodule

### hdl/prime_sieve_engine.sv
// A query reads the sieve table through its registered read port, and the result register loads
// the answer once it is free. A build request fills the table, then, for each odd candidate i
// with i*i below the limit, reads its table bit and crosses off the multiples of each prime; a
// last limit check ends the sweep. The engine takes no new request until its result is loaded.
// Reset (synchronous, active low) clears the state machine and the result valid flag, sets the
// limit register to 65536 and marks the table unbuilt; the table memory is rewritten by each build.
module prime_sieve_engine
    import pse_pkg::*;
#(
    parameter int SIEVE_SIZE = 65536
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pse_req_t           s_req,
    output logic               m_valid,
    input  logic               m_ready,
    output pse_resp_t          m_resp,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data
);

    // The controller sequences the build phases and query reads; the datapath owns the
    // limit register, the sieve counters, the table memory and the result register.
    pse_cmd_t    cmd;
    pse_status_t status;

    pse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .req_type (s_req.req_type),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pse_datapath #(
        .SIEVE_SIZE(SIEVE_SIZE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_req       (s_req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_resp      (m_resp)
    );

    // A prime answer is always a valid query answer.
    a_prime_is_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_resp.prime_flag) |-> m_resp.answer_valid)
        else $error("prime flag without a valid answer");

    // A build acknowledgment carries no query answer.
    a_build_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_resp.build_done) |-> !(m_resp.answer_valid || m_resp.prime_flag))
        else $error("build result carries a query answer");

endmodule
